[hdl/irn_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irn_pkg
// Shared types, constants and step tables of the Roman numeral converter.
// ----------------------------------------------------------------------------
package irn_pkg;

	localparam int VALUE_W  = 12;
	localparam int CHAR_W   = 7;
	localparam int STEP_CNT = 13;
	localparam int STEP_W   = $clog2(STEP_CNT);

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CHAR_W-1:0]  char_t;
	typedef logic [STEP_W-1:0]  step_idx_t;

	localparam value_t ROMAN_MIN = value_t'(1);
	localparam value_t ROMAN_MAX = value_t'(3999);

	localparam char_t NO_LETTER = char_t'(8'h00);
	localparam char_t CHAR_I    = char_t'(8'h49);
	localparam char_t CHAR_V    = char_t'(8'h56);
	localparam char_t CHAR_X    = char_t'(8'h58);
	localparam char_t CHAR_L    = char_t'(8'h4C);
	localparam char_t CHAR_C    = char_t'(8'h43);
	localparam char_t CHAR_D    = char_t'(8'h44);
	localparam char_t CHAR_M    = char_t'(8'h4D);

	typedef struct packed {
		logic load;
		logic advance;
	} irn_cmd_t;

	typedef struct packed {
		logic slot_free;
		logic last;
	} irn_sts_t;

	function automatic value_t step_value(input step_idx_t idx);
		value_t v;
		case (idx)
			step_idx_t'(0):  v = value_t'(1000);
			step_idx_t'(1):  v = value_t'(900);
			step_idx_t'(2):  v = value_t'(500);
			step_idx_t'(3):  v = value_t'(400);
			step_idx_t'(4):  v = value_t'(100);
			step_idx_t'(5):  v = value_t'(90);
			step_idx_t'(6):  v = value_t'(50);
			step_idx_t'(7):  v = value_t'(40);
			step_idx_t'(8):  v = value_t'(10);
			step_idx_t'(9):  v = value_t'(9);
			step_idx_t'(10): v = value_t'(5);
			step_idx_t'(11): v = value_t'(4);
			default:         v = value_t'(1);
		endcase
		return v;
	endfunction

	function automatic char_t first_letter(input step_idx_t idx);
		char_t c;
		case (idx)
			step_idx_t'(0):  c = CHAR_M;
			step_idx_t'(1):  c = CHAR_C;
			step_idx_t'(2):  c = CHAR_D;
			step_idx_t'(3):  c = CHAR_C;
			step_idx_t'(4):  c = CHAR_C;
			step_idx_t'(5):  c = CHAR_X;
			step_idx_t'(6):  c = CHAR_L;
			step_idx_t'(7):  c = CHAR_X;
			step_idx_t'(8):  c = CHAR_X;
			step_idx_t'(9):  c = CHAR_I;
			step_idx_t'(10): c = CHAR_V;
			default:         c = CHAR_I;
		endcase
		return c;
	endfunction

	function automatic char_t second_letter(input step_idx_t idx);
		char_t c;
		case (idx)
			step_idx_t'(1):  c = CHAR_M;
			step_idx_t'(3):  c = CHAR_D;
			step_idx_t'(5):  c = CHAR_C;
			step_idx_t'(7):  c = CHAR_L;
			step_idx_t'(9):  c = CHAR_X;
			step_idx_t'(11): c = CHAR_V;
			default:         c = NO_LETTER;
		endcase
		return c;
	endfunction

	// largest step value that still fits in rest
	function automatic step_idx_t greedy_step(input value_t rest);
		step_idx_t idx;
		idx = step_idx_t'(STEP_CNT - 1);
		for (int k = STEP_CNT - 1; k >= 0; k--) begin
			if (rest >= step_value(step_idx_t'(k))) begin
				idx = step_idx_t'(k);
			end
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

[hdl/irn_value_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irn_value_if
// Input channel: one integer per transfer.
// ----------------------------------------------------------------------------
interface irn_value_if;
	import irn_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);

endinterface
`default_nettype wire

[hdl/irn_char_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irn_char_if
// Output channel: one numeral letter per transfer.
// ----------------------------------------------------------------------------
interface irn_char_if;
	import irn_pkg::*;

	logic  valid;
	logic  ready;
	char_t numeral_char;
	logic  last_char;
	logic  range_error;

	modport source (output valid, output numeral_char, output last_char,
		output range_error, input ready);
	modport sink (input valid, input numeral_char, input last_char,
		input range_error, output ready);

endinterface
`default_nettype wire

[hdl/integer_to_roman_numeral.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_roman_numeral
// Converts an integer of 1 to 3999 into its Roman numeral, one ASCII letter
// per output transfer, last letter marked; other values give one error
// transfer.
//
//   channel   dir  payload                                  per transfer
//   numbers   in   value[11:0]                              one integer
//   letters   out  numeral_char[6:0] last_char range_error  one letter
//
// an integer is taken, then one letter leaves per cycle unless letters stalls;
// a numeral has up to 15 letters
// the greedy step pick over the thirteen values and one subtract set the
// per-letter cycle; numbers.ready rises as the last letter enters the
// output register, even while that letter waits to be taken
// a stall on letters holds the output register and pauses the converter
// reset clears the controller, the pending-letter flag and the output valid flag
// ----------------------------------------------------------------------------
module integer_to_roman_numeral (
	input  wire clk,
	input  wire arst_n,
	irn_value_if.sink numbers,
	irn_char_if.source letters
);
	import irn_pkg::*;

	irn_cmd_t cmd;
	irn_sts_t sts;

	irn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (numbers.valid),
		.in_ready (numbers.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	irn_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.value        (numbers.value),
		.out_valid    (letters.valid),
		.out_ready    (letters.ready),
		.numeral_char (letters.numeral_char),
		.last_char    (letters.last_char),
		.range_error  (letters.range_error)
	);

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		letters.valid && letters.range_error |->
			(letters.numeral_char == NO_LETTER) && letters.last_char)
		else $error("error transfer without zero letter and last mark");

	a_busy_after_take: assert property (@(posedge clk) disable iff (!arst_n)
		numbers.valid && numbers.ready |=> !numbers.ready)
		else $error("integer taken while previous one still converting");

	a_mid_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		letters.valid && !letters.last_char |-> !numbers.ready)
		else $error("converter idle with a numeral still unfinished");

	a_no_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.advance |-> !numbers.ready)
		else $error("letter produced while idle");

endmodule
`default_nettype wire

[hdl/irn_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irn_ctrl
// Controller: takes an integer, then steps the datapath once per letter.
// ----------------------------------------------------------------------------
module irn_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  irn_pkg::irn_sts_t sts,
	output irn_pkg::irn_cmd_t cmd
);
	import irn_pkg::*;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;

	assign in_ready    = (state_q == ST_IDLE);
	assign cmd.load    = in_ready && in_valid;
	assign cmd.advance = (state_q == ST_RUN) && sts.slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.advance && sts.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/irn_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irn_dp
// Datapath: remainder, pending second letter, greedy step pick and the
// output register.
// ----------------------------------------------------------------------------
module irn_dp (
	input  wire               clk,
	input  wire               arst_n,
	input  irn_pkg::irn_cmd_t cmd,
	output irn_pkg::irn_sts_t sts,
	input  irn_pkg::value_t   value,
	output logic              out_valid,
	input  wire               out_ready,
	output irn_pkg::char_t    numeral_char,
	output logic              last_char,
	output logic              range_error
);
	import irn_pkg::*;

	value_t    rest_q;
	logic      err_q;
	logic      pend_q;
	char_t     pend_char_q;
	logic      out_valid_q;
	char_t     out_char_q;
	logic      out_last_q;
	logic      out_err_q;

	step_idx_t step;
	value_t    step_v;
	char_t     first_c;
	char_t     second_c;
	value_t    diff;
	char_t     emit_char;
	logic      emit_last;
	logic      load_err;

	assign load_err = (value < ROMAN_MIN) || (value > ROMAN_MAX);

	assign step     = greedy_step(rest_q);
	assign step_v   = step_value(step);
	assign first_c  = first_letter(step);
	assign second_c = second_letter(step);
	assign diff     = rest_q - step_v;

	always_comb begin
		if (err_q) begin
			emit_char = NO_LETTER;
			emit_last = 1'b1;
		end else if (pend_q) begin
			emit_char = pend_char_q;
			emit_last = (rest_q == '0);
		end else begin
			emit_char = first_c;
			emit_last = (second_c == NO_LETTER) && (diff == '0);
		end
	end

	assign sts.slot_free = !out_valid_q || out_ready;
	assign sts.last      = emit_last;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rest_q <= value;
			err_q  <= load_err;
		end else if (cmd.advance && !err_q && !pend_q) begin
			rest_q <= diff;
		end
		if (!pend_q) begin
			pend_char_q <= second_c;
		end
		if (cmd.advance) begin
			out_char_q <= emit_char;
			out_last_q <= emit_last;
			out_err_q  <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				pend_q <= 1'b0;
			end else if (cmd.advance) begin
				pend_q <= !pend_q && !err_q && (second_c != NO_LETTER);
			end
			if (cmd.advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign numeral_char = out_char_q;
	assign last_char    = out_last_q;
	assign range_error  = out_err_q;

endmodule
`default_nettype wire
